// ===== rtl/pag_pkg.sv =====
package pag_pkg;

	// Fixed field widths.
	localparam int DotW  = 16;
	localparam int DistW = 32;
	localparam int GainW = 16;
	localparam int NumW  = 48;
	localparam int QuoW  = 16;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_BLOOM        = 2'd0,
		REG_MIN_DISTANCE = 2'd1,
		REG_MAX_DISTANCE = 2'd2,
		REG_FLOOR_VOLUME = 2'd3
	} cfg_reg_t;

	// Fixed-point constants, Q1.15 except NEAR_LIMIT, which is a distance.
	localparam logic [16:0] ONE_Q15    = 17'd32768;
	localparam logic [31:0] NEAR_LIMIT = 32'd656;
	localparam logic [15:0] FLAT_LIMIT = 16'd32440;
	localparam logic [15:0] MIN_VOL    = 16'd164;
	localparam logic [15:0] DOT_BASE   = 16'd8192;

	// Reset values of the registers.
	localparam logic [15:0] BLOOM_RST = 16'd16384;
	localparam logic [31:0] MIN_RST   = 32'd65536;
	localparam logic [31:0] MAX_RST   = 32'd983040;
	localparam logic [15:0] FLOOR_RST = 16'd0;

	// Side data that travels with an item through the divider stages.
	typedef struct packed {
		logic [15:0] d;
		logic        near;
		logic        flat;
		logic        lt_min;
		logic        ge_max;
		logic [3:0]  shift;
		logic [16:0] la;
		logic [16:0] lc;
		logic [8:0]  lrem;
	} side_t;

	// Integer square root, used only while the tables are built.
	function automatic logic [63:0] isqrt64(input logic [63:0] value);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bt;
		v = value;
		r = 64'd0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 64'd0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Q1.16 entry of log2(1 + i/2^b), by repeated squaring.
	function automatic logic [16:0] log_entry(input int i, input int b);
		logic [63:0] x;
		logic [16:0] res;
		x = (64'd1 << 30) + (64'(i) << (30 - b));
		res = 17'd0;
		if (x >= (64'd1 << 31)) begin
			res = 17'd65536;
			x = x >> 1;
		end
		for (int bp = 15; bp >= 0; bp--) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				res = res | (17'd1 << bp);
				x = x >> 1;
			end
		end
		return res;
	endfunction

	// Q2.30 entry of 2^(i/2^b), as a product of repeated square roots of two.
	function automatic logic [31:0] exp_entry(input int i, input int b);
		logic [63:0] root [13];
		logic [63:0] v;
		root[0] = 64'd1 << 31;
		root[1] = isqrt64(64'd2 << 60);
		for (int k = 2; k < 13; k++) root[k] = isqrt64(root[k - 1] << 30);
		if (i == (1 << b)) begin
			v = 64'd1 << 31;
		end else begin
			v = 64'd1 << 30;
			for (int bb = 0; bb < b; bb++) begin
				if (((i >> bb) & 1) != 0) v = (v * root[b - bb]) >> 30;
			end
		end
		return v[31:0];
	endfunction

endpackage

// ===== rtl/pag_in_if.sv =====
interface pag_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] direction_dot;
	logic [31:0] source_distance;

	modport source (output valid, output direction_dot, output source_distance, input ready);
	modport sink (input valid, input direction_dot, input source_distance, output ready);
endinterface

// ===== rtl/pag_out_if.sv =====
interface pag_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] gain;

	modport source (output valid, output gain, input ready);
	modport sink (input valid, input gain, output ready);
endinterface

// ===== rtl/pag_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QuoW bits: num < den * 2^QuoW.
module pag_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pag_pkg::NumW-1:0]   num,
	input  logic [31:0]                den,
	output logic [pag_pkg::QuoW-1:0]   quo
);

	localparam int N = pag_pkg::QuoW;
	localparam int W = pag_pkg::NumW;

	logic [W-1:0] rem_s [N];
	logic [31:0]  den_s [N];
	logic [N-1:0] quo_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W-1:0] rem_in;
		logic [31:0]  den_in;
		logic [N-1:0] quo_in;
		logic [W:0]   shifted;
		logic         take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k - 1];
			assign den_in = den_s[k - 1];
			assign quo_in = quo_s[k - 1];
		end

		// Trial subtraction of the divisor aligned to this quotient bit.
		assign shifted = {{(W + 1 - 32){1'b0}}, den_in} << (N - 1 - k);
		assign take = {1'b0, rem_in} >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? W'({1'b0, rem_in} - shifted) : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_in | (N'(take) << (N - 1 - k));
			end
		end
	end

	assign quo = quo_s[N - 1];

endmodule

// ===== rtl/positional_audio_gain.sv =====
// Path from an input transfer to the output register: stages 1 and 2, the divider stages, stages 3 to 8.
// Throughput: one item per cycle; a held result stalls the whole pipeline in place.
// The two 16-stage pipelined dividers set the depth.
// Reset (arst_n low, asynchronous) clears the valid bits and sets the
// configuration registers to their defaults; the tables are constants.
module positional_audio_gain #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	pag_in_if.sink      in_ch,
	pag_out_if.source   out_ch
);

	localparam int B      = LOG_TABLE_BITS;
	localparam int TAB    = (1 << B) + 1;
	localparam int LSH    = 15 - B;
	localparam int ESH    = 16 - B;
	localparam int DSTG   = pag_pkg::QuoW;
	localparam logic [B:0] LAST = (B + 1)'(1 << B);

	// Constant tables.
	logic [16:0] log_rom [TAB];
	logic [31:0] exp_rom [TAB];
	for (genvar i = 0; i < TAB; i++) begin : g_rom
		assign log_rom[i] = pag_pkg::log_entry(i, B);
		assign exp_rom[i] = pag_pkg::exp_entry(i, B);
	end

	// Configuration registers.
	logic [15:0] bloom_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [15:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bloom_q <= pag_pkg::BLOOM_RST;
			min_q   <= pag_pkg::MIN_RST;
			max_q   <= pag_pkg::MAX_RST;
			floor_q <= pag_pkg::FLOOR_RST;
		end else if (cfg_we) begin
			case (pag_pkg::cfg_reg_t'(cfg_index))
				pag_pkg::REG_BLOOM:        bloom_q <= cfg_data[15:0];
				pag_pkg::REG_MIN_DISTANCE: min_q   <= cfg_data;
				pag_pkg::REG_MAX_DISTANCE: max_q   <= cfg_data;
				pag_pkg::REG_FLOOR_VOLUME: floor_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Global advance: the pipeline moves unless a result is held.
	logic en;
	logic vld_s8;
	assign en = !vld_s8 || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: dot factor, case flags, distance differences, volume normalization.
	logic [15:0] x_c;
	logic [17:0] x3_c;
	logic [15:0] vol_c;
	logic [3:0]  sh_c;
	logic [15:0] n_c;

	assign x_c  = in_ch.direction_dot ^ 16'h8000;
	assign x3_c = {2'b00, x_c} + {1'b0, x_c, 1'b0};

	always_comb begin
		if (floor_q < pag_pkg::MIN_VOL) vol_c = pag_pkg::MIN_VOL;
		else if ({1'b0, floor_q} > pag_pkg::ONE_Q15) vol_c = 16'(pag_pkg::ONE_Q15);
		else vol_c = floor_q;
	end

	// Leading one of the volume, which is known to lie in bits 7 to 15.
	always_comb begin
		sh_c = 4'd8;
		for (int k = 8; k <= 15; k++) begin
			if (vol_c[k]) sh_c = 4'(15 - k);
		end
	end
	assign n_c = vol_c << sh_c;

	logic        vld_s1;
	logic [15:0] d_s1;
	logic        near_s1, flat_s1, lt_s1, ge_s1;
	logic [31:0] a_s1, b_s1;
	logic [3:0]  sh_s1;
	logic [14:0] f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= pag_pkg::DOT_BASE + 16'(x3_c >> 3);
			near_s1 <= in_ch.source_distance < pag_pkg::NEAR_LIMIT;
			flat_s1 <= floor_q > pag_pkg::FLAT_LIMIT;
			lt_s1   <= in_ch.source_distance < min_q;
			ge_s1   <= in_ch.source_distance >= max_q;
			a_s1    <= min_q - in_ch.source_distance;
			b_s1    <= in_ch.source_distance - min_q;
			sh_s1   <= sh_c;
			f_s1    <= n_c[14:0];
		end
	end

	// Stage 2: bloom product and log table lookup.
	logic [B-1:0]   lidx_c;
	logic [B:0]     lidx_w;
	assign lidx_c = f_s1[14:LSH];
	assign lidx_w = {1'b0, lidx_c};

	logic                     vld_s2;
	logic [pag_pkg::NumW-1:0] fnum_s2;
	logic [pag_pkg::NumW-1:0] rnum_s2;
	pag_pkg::side_t           side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fnum_s2        <= {32'd0, bloom_q} * {16'd0, a_s1};
			rnum_s2        <= {b_s1, 16'd0};
			side_s2.d      <= d_s1;
			side_s2.near   <= near_s1;
			side_s2.flat   <= flat_s1;
			side_s2.lt_min <= lt_s1;
			side_s2.ge_max <= ge_s1;
			side_s2.shift  <= sh_s1;
			side_s2.la     <= log_rom[lidx_w];
			side_s2.lc     <= log_rom[lidx_w + 1'b1];
			side_s2.lrem   <= 9'(f_s1[LSH-1:0]);
		end
	end

	// Divider stages: bloom fade and relative distance.
	logic [pag_pkg::QuoW-1:0] fade_c;
	logic [pag_pkg::QuoW-1:0] rel_c;
	logic [31:0]              span_c;
	assign span_c = max_q - min_q;

	pag_div u_fade_div (
		.clk (clk),
		.en  (en),
		.num (fnum_s2),
		.den (min_q),
		.quo (fade_c)
	);

	pag_div u_rel_div (
		.clk (clk),
		.en  (en),
		.num (rnum_s2),
		.den (span_c),
		.quo (rel_c)
	);

	// Side data and valid bits follow the divider stages.
	pag_pkg::side_t side_dly_s [DSTG];
	logic [DSTG-1:0] vld_dly_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_dly_s <= '0;
		else if (en) vld_dly_s <= {vld_dly_s[DSTG-2:0], vld_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_s[0] <= side_s2;
			for (int k = 1; k < DSTG; k++) side_dly_s[k] <= side_dly_s[k - 1];
		end
	end

	pag_pkg::side_t side_c;
	assign side_c = side_dly_s[DSTG - 1];

	// Stage 3: log interpolation, negated log of the volume, fade sum.
	logic [16:0]       ldiff_c;
	logic [16+LSH:0]   lmul_c;
	logic [16:0]       lf_c;
	logic [19:0]       lbase_c;

	assign ldiff_c = (side_c.lc > side_c.la) ? side_c.lc - side_c.la : 17'd0;
	assign lmul_c  = {{LSH{1'b0}}, ldiff_c} * {{17{1'b0}}, side_c.lrem[LSH-1:0]};
	assign lf_c    = side_c.la + 17'(lmul_c >> LSH);
	assign lbase_c = {side_c.shift, 16'd0};

	logic        vld_s3;
	logic [19:0] negl_s3;
	logic [15:0] rel_s3;
	logic [16:0] attn_s3;
	logic [15:0] d_s3;
	logic        near_s3, flat_s3, lt_s3, ge_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_dly_s[DSTG - 1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negl_s3 <= (lbase_c < {3'd0, lf_c}) ? 20'd0 : lbase_c - {3'd0, lf_c};
			rel_s3  <= rel_c;
			attn_s3 <= {1'b0, side_c.d} + {1'b0, fade_c};
			d_s3    <= side_c.d;
			near_s3 <= side_c.near;
			flat_s3 <= side_c.flat;
			lt_s3   <= side_c.lt_min;
			ge_s3   <= side_c.ge_max;
		end
	end

	// Stage 4: scaled log, split into whole and fractional parts.
	logic [35:0] p_c;
	assign p_c = {16'd0, negl_s3} * {20'd0, rel_s3};

	logic        vld_s4;
	logic [16:0] h_s4;
	logic [3:0]  k_s4;
	logic [16:0] attn_s4;
	logic [15:0] d_s4;
	logic        near_s4, flat_s4, lt_s4, ge_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s4    <= 17'd65536 - {1'b0, p_c[31:16]};
			k_s4    <= p_c[35:32];
			attn_s4 <= attn_s3;
			d_s4    <= d_s3;
			near_s4 <= near_s3;
			flat_s4 <= flat_s3;
			lt_s4   <= lt_s3;
			ge_s4   <= ge_s3;
		end
	end

	// Stage 5: exp table lookup.
	logic [B:0] eidx_c;
	logic [B:0] enxt_c;
	assign eidx_c = h_s4[16:ESH];
	assign enxt_c = (eidx_c == LAST) ? eidx_c : eidx_c + 1'b1;

	logic        vld_s5;
	logic [31:0] ea_s5, ec_s5;
	logic [9:0]  erem_s5;
	logic [3:0]  k_s5;
	logic [16:0] attn_s5;
	logic [15:0] d_s5;
	logic        near_s5, flat_s5, lt_s5, ge_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s5   <= exp_rom[eidx_c];
			ec_s5   <= exp_rom[enxt_c];
			erem_s5 <= 10'(h_s4[ESH-1:0]);
			k_s5    <= k_s4;
			attn_s5 <= attn_s4;
			d_s5    <= d_s4;
			near_s5 <= near_s4;
			flat_s5 <= flat_s4;
			lt_s5   <= lt_s4;
			ge_s5   <= ge_s4;
		end
	end

	// Stage 6: exp interpolation, shift by the whole part, attenuation select.
	logic [31:0]     ediff_c;
	logic [31+ESH:0] emul_c;
	logic [31:0]     v_c;
	logic [31:0]     pw_c;

	assign ediff_c = (ec_s5 > ea_s5) ? ec_s5 - ea_s5 : 32'd0;
	assign emul_c  = {{ESH{1'b0}}, ediff_c} * {{32{1'b0}}, erem_s5[ESH-1:0]};
	assign v_c     = ea_s5 + 32'(emul_c >> ESH);
	assign pw_c    = v_c >> (5'd16 + {1'b0, k_s5});

	logic        vld_s6;
	logic [15:0] datt_s6;
	logic [16:0] attn_s6;
	logic [15:0] d_s6;
	logic        near_s6, flat_s6, lt_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			datt_s6 <= ge_s5 ? floor_q : pw_c[15:0];
			attn_s6 <= attn_s5;
			d_s6    <= d_s5;
			near_s6 <= near_s5;
			flat_s6 <= flat_s5;
			lt_s6   <= lt_s5;
		end
	end

	// Stage 7: attenuation times dot factor.
	logic [31:0] ad_c;
	assign ad_c = {16'd0, datt_s6} * {16'd0, d_s6};

	logic        vld_s7;
	logic [16:0] attp_s7;
	logic [16:0] attn_s7;
	logic [16:0] attb_s7;
	logic        near_s7, flat_s7, lt_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			attp_s7 <= ad_c[31:15];
			attn_s7 <= attn_s6;
			attb_s7 <= {1'b0, d_s6} + {1'b0, bloom_q};
			near_s7 <= near_s6;
			flat_s7 <= flat_s6;
			lt_s7   <= lt_s6;
		end
	end

	// Stage 8: case select and saturation into the output register.
	logic [16:0] att_c;
	always_comb begin
		if (near_s7) att_c = pag_pkg::ONE_Q15;
		else if (flat_s7) att_c = attb_s7;
		else if (lt_s7) att_c = attn_s7;
		else att_c = attp_s7;
	end

	logic [15:0] gain_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gain_s8 <= (att_c > pag_pkg::ONE_Q15) ? 16'(pag_pkg::ONE_Q15) : att_c[15:0];
		end
	end

	assign out_ch.valid = vld_s8;
	assign out_ch.gain  = gain_s8;

endmodule

// ===== tb/tb_positional_audio_gain.sv =====
module tb_positional_audio_gain;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TabBits = 8;
	localparam int TabLen  = (1 << TabBits) + 1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	pag_in_if  in_ch ();
	pag_out_if out_ch ();

	positional_audio_gain dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow copy of the configuration registers.
	logic [15:0] bloom_q;
	logic [31:0] min_dist_q;
	logic [31:0] max_dist_q;
	logic [15:0] floor_q;

	longint unsigned log2_rom [TabLen];
	longint unsigned exp2_rom [TabLen];

	logic [15:0] gain_expected [$];
	int          err_cnt;
	int          send_gap_pct;
	int          recv_stall_pct;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	function automatic longint unsigned root_u64(input longint unsigned value);
		longint unsigned v;
		longint unsigned r;
		longint unsigned bt;
		v = value;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Fill the log2 and exp2 tables by integer arithmetic.
	task automatic build_roms();
		longint unsigned roots [13];
		longint unsigned x;
		longint unsigned v;
		longint unsigned res;
		roots[0] = 64'd1 << 31;
		roots[1] = root_u64(64'd2 << 60);
		for (int k = 2; k < 13; k++) roots[k] = root_u64(roots[k - 1] << 30);
		for (int i = 0; i < TabLen; i++) begin
			x = (64'd1 << 30) + (longint'(i) << (30 - TabBits));
			res = 0;
			if (x >= (64'd1 << 31)) begin
				res = 65536;
				x = x >> 1;
			end
			for (int bp = 15; bp >= 0; bp--) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					res = res | (64'd1 << bp);
					x = x >> 1;
				end
			end
			log2_rom[i] = res;
			if (i == TabLen - 1) begin
				exp2_rom[i] = 64'd1 << 31;
			end else begin
				v = 64'd1 << 30;
				for (int bb = 0; bb < TabBits; bb++)
					if (((i >> bb) & 1) != 0) v = (v * roots[TabBits - bb]) >> 30;
				exp2_rom[i] = v & 64'hFFFF_FFFF;
			end
		end
	endtask

	// Linear interpolation between neighboring table entries.
	function automatic longint unsigned lerp_rom(input bit use_exp, input int idx,
			input longint unsigned rem, input int sh);
		longint unsigned a;
		longint unsigned c;
		a = use_exp ? exp2_rom[idx] : log2_rom[idx];
		if (idx + 1 >= TabLen) return a;
		c = use_exp ? exp2_rom[idx + 1] : log2_rom[idx + 1];
		if (c <= a) return a;
		return a + (((c - a) * rem) >> sh);
	endfunction

	// vol^rel, vol in Q1.15 and rel in Q0.16, result in Q1.15.
	function automatic longint unsigned curve_volume(input longint unsigned vol,
			input longint unsigned rel);
		int              e;
		longint unsigned f;
		longint unsigned lf;
		longint unsigned negl;
		longint unsigned p;
		longint unsigned k;
		longint unsigned h;
		longint unsigned v;
		e = 15;
		while (e > 0 && vol[e] == 1'b0) e--;
		f = (vol << (15 - e)) - 32768;
		lf = lerp_rom(1'b0, int'(f >> (15 - TabBits)),
			f & ((64'd1 << (15 - TabBits)) - 1), 15 - TabBits);
		if (longint'(15 - e) * 65536 < lf) negl = 0;
		else negl = longint'(15 - e) * 65536 - lf;
		p = (negl * rel) >> 16;
		k = p >> 16;
		h = 65536 - (p & 64'hFFFF);
		v = lerp_rom(1'b1, int'(h >> (16 - TabBits)),
			h & ((64'd1 << (16 - TabBits)) - 1), 16 - TabBits);
		if (16 + k >= 32) return 0;
		return v >> (16 + k);
	endfunction

	// Expected gain for one source under the current shadow configuration.
	function automatic logic [15:0] predict_gain(input logic [15:0] dot,
			input logic [31:0] src_dist);
		longint unsigned d;
		longint unsigned att;
		longint unsigned datt;
		longint unsigned vol;
		longint unsigned rel;
		d = 8192 + ((3 * longint'(dot ^ 16'h8000)) >> 3);
		if (src_dist < pag_pkg::NEAR_LIMIT) begin
			att = pag_pkg::ONE_Q15;
		end else if (floor_q > pag_pkg::FLAT_LIMIT) begin
			att = d + bloom_q;
		end else if (src_dist < min_dist_q) begin
			att = d + (longint'(bloom_q) * (min_dist_q - src_dist)) / min_dist_q;
		end else begin
			if (src_dist >= max_dist_q) begin
				datt = floor_q;
			end else begin
				vol = floor_q;
				if (vol < pag_pkg::MIN_VOL) vol = pag_pkg::MIN_VOL;
				if (vol > pag_pkg::ONE_Q15) vol = pag_pkg::ONE_Q15;
				rel = (longint'(src_dist - min_dist_q) << 16) /
					longint'(max_dist_q - min_dist_q);
				datt = curve_volume(vol, rel);
			end
			att = (datt * d) >> 15;
		end
		if (att > pag_pkg::ONE_Q15) att = pag_pkg::ONE_Q15;
		return att[15:0];
	endfunction

	task automatic report_mismatch(input string what, input int expd, input int got);
		$display("mismatch %s: expected %0d got %0d at %0t", what, expd, got, $realtime);
		err_cnt++;
	endtask

	// Receiver: random back-pressure on the result channel.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (gain_expected.size() == 0) begin
				report_mismatch("unexpected gain", -1, out_ch.gain);
			end else begin
				if (out_ch.gain !== gain_expected[0])
					report_mismatch("gain", gain_expected[0], out_ch.gain);
				void'(gain_expected.pop_front());
			end
		end
	end

	// Send one source; returns at the edge where the transfer happens.
	task automatic send_source(input logic [15:0] dot, input logic [31:0] src_dist);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.direction_dot <= dot;
		in_ch.source_distance <= src_dist;
		do @(posedge clk); while (!in_ch.ready);
		gain_expected.push_back(predict_gain(dot, src_dist));
	endtask

	// Let the pipeline empty out before touching the registers.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (gain_expected.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Drive one register write; the caller drops the write enable afterwards.
	task automatic write_reg(input pag_pkg::cfg_reg_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			pag_pkg::REG_BLOOM:        bloom_q = value[15:0];
			pag_pkg::REG_MIN_DISTANCE: min_dist_q = value;
			pag_pkg::REG_MAX_DISTANCE: max_dist_q = value;
			default:                   floor_q = value[15:0];
		endcase
	endtask

	task automatic set_scene(input logic [15:0] bl, input logic [31:0] mn,
			input logic [31:0] mx, input logic [15:0] fl);
		drain();
		write_reg(pag_pkg::REG_BLOOM, {16'($urandom), bl});
		write_reg(pag_pkg::REG_MIN_DISTANCE, mn);
		write_reg(pag_pkg::REG_MAX_DISTANCE, mx);
		write_reg(pag_pkg::REG_FLOOR_VOLUME, {16'($urandom), fl});
		cfg_we <= 1'b0;
	endtask

	// Distance edges of the current scene against a few dot values.
	task automatic test_distance_edges();
		logic [31:0] dists [10];
		dists = '{0, 655, 656, min_dist_q - 1, min_dist_q, min_dist_q + 1,
			max_dist_q - 1, max_dist_q, 32'hFFFF_FFFF, 32'h0001_8000};
		foreach (dists[i]) send_source(16'h8000, dists[i]);
		send_source(16'h7FFF, min_dist_q + 100);
		send_source(16'h0000, max_dist_q - 5);
	endtask

	// Defaults after reset, then the flat and degenerate cases.
	task automatic test_directed();
		test_distance_edges();
		set_scene(16'd32768, 32'd65536, 32'd983040, 16'd32441);
		send_source(16'h7FFF, 32'd100000);
		send_source(16'h8000, 32'd700);
		set_scene(16'hFFFF, 32'd0, 32'd0, 16'hFFFF);
		send_source(16'h1234, 32'd5000);
		set_scene(16'd0, 32'd0, 32'd65536, 16'd32440);
		send_source(16'hC000, 32'd30000);
		send_source(16'h4000, 32'd70000);
		set_scene(16'd20000, 32'd200000, 32'd100000, 16'd500);
		send_source(16'h0000, 32'd150000);
		send_source(16'h0000, 32'd250000);
		set_scene(16'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd32768);
		send_source(16'h7FFF, 32'h8000_0000);
	endtask

	function automatic logic [31:0] pick_distance();
		longint unsigned span;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1000);
			2: return min_dist_q + $urandom_range(0, 64) - 32;
			3: return max_dist_q + $urandom_range(0, 64) - 32;
			default: begin
				if (max_dist_q > min_dist_q) begin
					span = longint'(max_dist_q) - min_dist_q + 1;
					return min_dist_q + 32'(({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF) % span);
				end
				return $urandom_range(0, 2000000);
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_q15(input int top);
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	// Random scenes with random sources.
	task automatic test_random_scenes(input int scenes, input int per_scene);
		logic [31:0] mn;
		logic [31:0] mx;
		for (int s = 0; s < scenes; s++) begin
			case ($urandom_range(0, 5))
				0: mn = 32'd0;
				1: mn = $urandom;
				default: mn = $urandom_range(0, 20 * 65536);
			endcase
			case ($urandom_range(0, 5))
				0: mx = mn;
				1: mx = 32'hFFFF_FFFF;
				2: mx = $urandom_range(0, 20 * 65536);
				default: mx = mn + $urandom_range(1, 40 * 65536);
			endcase
			set_scene(pick_q15(32768), mn, mx, pick_q15(32440));
			for (int i = 0; i < per_scene; i++) send_source(16'($urandom), pick_distance());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pag_pkg::REG_BLOOM;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.direction_dot = '0;
		in_ch.source_distance = '0;
		out_ch.ready = 1'b0;
		err_cnt = 0;
		send_gap_pct = 30;
		recv_stall_pct = 48;
		bloom_q = pag_pkg::BLOOM_RST;
		min_dist_q = pag_pkg::MIN_RST;
		max_dist_q = pag_pkg::MAX_RST;
		floor_q = pag_pkg::FLOOR_RST;
		build_roms();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_scenes(6, 95);
		send_gap_pct = 48;
		recv_stall_pct = 30;
		test_random_scenes(6, 95);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_scenes(6, 95);

		drain();
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/pag_pkg.sv
rtl/pag_in_if.sv
rtl/pag_out_if.sv
rtl/pag_div.sv
rtl/positional_audio_gain.sv
tb/tb_positional_audio_gain.sv
